### sv/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] rec;
        logic [7:0]  age;
    } t_entry;

    // Map a queue position to a storage slot of the circular buffer.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (IDX_W+1)'(CAPACITY)) begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

### sv/sorted_priority_queue.sv
// Sorted priority queue on a circular buffer, one read and one write port.
// Steps: a full insert or an empty remove answers from idle; a remove pops the
// head in S_POP; an insert walks the stored entries of lower priority, one per
// cycle through the read port in S_CMP, then writes the new entry into the hole.
// Throughput: one request at a time; busy is high until the result strobe.
// Synchronous active-low reset empties the queue; results cannot be stalled.
module sorted_priority_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [7:0]                 i_new_priority,
    input  logic [15:0]                i_new_record,
    input  logic [7:0]                 i_new_age,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [7:0]                 o_out_priority,
    output logic [15:0]                o_out_record,
    output logic [7:0]                 o_out_age,
    output logic [spq_pkg::CNT_W-1:0]  o_occupancy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_PLACE = 4'b0100,
        S_POP   = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [spq_pkg::IDX_W-1:0]   r_head, n_head;
    logic [spq_pkg::CNT_W-1:0]   r_count, n_count;
    logic [spq_pkg::IDX_W-1:0]   r_pos, n_pos;
    spq_pkg::t_entry             r_new, n_new;

    logic                        r_valid, n_valid;
    spq_pkg::t_status            r_status, n_status;
    spq_pkg::t_entry             r_out, n_out;
    logic [spq_pkg::CNT_W-1:0]   r_occ, n_occ;

    spq_pkg::t_entry             r_mem [spq_pkg::CAPACITY];
    spq_pkg::t_entry             r_rd_data;
    logic [spq_pkg::IDX_W-1:0]   rd_addr;
    logic                        wr_en;
    logic [spq_pkg::IDX_W-1:0]   wr_addr;
    spq_pkg::t_entry             wr_data;
    logic [spq_pkg::CNT_W-1:0]   count_m1;

    assign count_m1 = r_count - 1'b1;
    assign busy     = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_pos    = r_pos;
        n_new    = r_new;
        n_valid  = 1'b0;
        n_status = r_status;
        n_out    = r_out;
        n_occ    = r_occ;
        wr_en    = 1'b0;
        wr_addr  = spq_pkg::slot_of(r_head, r_pos);
        wr_data  = r_new;
        rd_addr  = spq_pkg::slot_of(r_head, count_m1[spq_pkg::IDX_W-1:0]);

        case (r_state)
            S_IDLE: begin
                if (i_opcode == spq_pkg::OP_REMOVE) begin
                    rd_addr = r_head;
                end
                if (start) begin
                    n_new = '{prio: i_new_priority, rec: i_new_record, age: i_new_age};
                    if (i_opcode == spq_pkg::OP_REMOVE) begin
                        if (r_count == '0) begin
                            n_valid  = 1'b1;
                            n_status = spq_pkg::ST_EMPTY;
                            n_out    = '0;
                            n_occ    = r_count;
                        end else begin
                            n_state = S_POP;
                        end
                    end else begin
                        if (r_count >= spq_pkg::CAP_COUNT) begin
                            n_valid  = 1'b1;
                            n_status = spq_pkg::ST_FULL;
                            n_out    = '0;
                            n_occ    = r_count;
                        end else if (r_count == '0) begin
                            n_pos   = '0;
                            n_state = S_PLACE;
                        end else begin
                            // hole sits at the tail; compare against the last entry
                            n_pos   = r_count[spq_pkg::IDX_W-1:0];
                            n_state = S_CMP;
                        end
                    end
                end
            end
            S_CMP: begin
                wr_en = 1'b1;
                if (r_rd_data.prio >= r_new.prio) begin
                    // drop the new entry into the hole behind an equal or higher one
                    n_count  = r_count + 1'b1;
                    n_valid  = 1'b1;
                    n_status = spq_pkg::ST_DONE;
                    n_out    = '0;
                    n_occ    = r_count + 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    // move the lower entry back one place, advance the hole forward
                    wr_data = r_rd_data;
                    n_pos   = r_pos - 1'b1;
                    rd_addr = spq_pkg::slot_of(r_head, r_pos - spq_pkg::IDX_W'(2));
                    if (r_pos == spq_pkg::IDX_W'(1)) begin
                        n_state = S_PLACE;
                    end
                end
            end
            S_PLACE: begin
                wr_en    = 1'b1;
                n_count  = r_count + 1'b1;
                n_valid  = 1'b1;
                n_status = spq_pkg::ST_DONE;
                n_out    = '0;
                n_occ    = r_count + 1'b1;
                n_state  = S_IDLE;
            end
            S_POP: begin
                n_head   = spq_pkg::slot_of(r_head, spq_pkg::IDX_W'(1));
                n_count  = count_m1;
                n_valid  = 1'b1;
                n_status = spq_pkg::ST_DONE;
                n_out    = r_rd_data;
                n_occ    = count_m1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_new    <= n_new;
        r_status <= n_status;
        r_out    <= n_out;
        r_occ    <= n_occ;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_out.prio;
    assign o_out_record   = r_out.rec;
    assign o_out_age      = r_out.age;
    assign o_occupancy    = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CAP_COUNT)
        else $error("entry count above capacity");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe while still working");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_valid || busy))
        else $error("accepted request neither finished nor in progress");

    a_hole_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_pos != '0))
        else $error("compare step with hole at the front");

    a_count_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> r_valid)
        else $error("entry count changed without a result");

endmodule

### sim/tb_sorted_priority_queue.sv
module tb_sorted_priority_queue;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        spq_pkg::t_status          status;
        spq_pkg::t_entry           removed;
        logic [spq_pkg::CNT_W-1:0] occupancy;
    } t_outcome;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    spq_pkg::t_opcode  req_opcode = spq_pkg::OP_INSERT;
    logic [7:0]        req_priority = '0;
    logic [15:0]       req_record = '0;
    logic [7:0]        req_age = '0;

    logic                      o_valid;
    logic [1:0]                o_status;
    logic [7:0]                o_out_priority;
    logic [15:0]               o_out_record;
    logic [7:0]                o_out_age;
    logic [spq_pkg::CNT_W-1:0] o_occupancy;

    // Shadow copy of the queue contents, front at index 0.
    spq_pkg::t_entry shadow_slots[spq_pkg::CAPACITY];
    int              shadow_count = 0;
    t_outcome        expected_outcomes[$];
    int              mismatch_count = 0;
    int              stall_cycles = 0;

    sorted_priority_queue DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (req_opcode),
        .i_new_priority (req_priority),
        .i_new_record   (req_record),
        .i_new_age      (req_age),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_priority (o_out_priority),
        .o_out_record   (o_out_record),
        .o_out_age      (o_out_age),
        .o_occupancy    (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Apply one request to the shadow queue and return the outcome it must give.
    function automatic t_outcome apply_request(input spq_pkg::t_opcode op,
                                               input spq_pkg::t_entry item);
        t_outcome res;
        int       pos;
        int       i;
        res.status  = spq_pkg::ST_DONE;
        res.removed = '0;
        if (op == spq_pkg::OP_INSERT) begin
            if (shadow_count >= spq_pkg::CAPACITY) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                // walk past every entry of equal or higher priority
                while (pos < shadow_count && shadow_slots[pos].prio >= item.prio) begin
                    pos++;
                end
                for (i = shadow_count; i > pos; i--) begin
                    shadow_slots[i] = shadow_slots[i - 1];
                end
                shadow_slots[pos] = item;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                res.removed = shadow_slots[0];
                for (i = 1; i < shadow_count; i++) begin
                    shadow_slots[i - 1] = shadow_slots[i];
                end
                shadow_count--;
            end
        end
        res.occupancy = spq_pkg::CNT_W'(shadow_count);
        return res;
    endfunction

    function automatic spq_pkg::t_entry random_entry(input bit tie_heavy);
        spq_pkg::t_entry e;
        e.prio = tie_heavy ? 8'($urandom_range(0, 3) * 85) : 8'($urandom_range(0, 255));
        e.rec  = 16'($urandom);
        e.age  = 8'($urandom);
        return e;
    endfunction

    function automatic spq_pkg::t_entry make_entry(input logic [7:0] p,
                                                   input logic [15:0] r,
                                                   input logic [7:0] a);
        spq_pkg::t_entry e;
        e.prio = p;
        e.rec  = r;
        e.age  = a;
        return e;
    endfunction

    // Hold the request until the block takes it, then record the expected outcome.
    task automatic send_request(input spq_pkg::t_opcode op, input spq_pkg::t_entry item);
        if (!start) begin
            start <= 1'b1;
        end
        req_opcode   <= op;
        req_priority <= item.prio;
        req_record   <= item.rec;
        req_age      <= item.age;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        expected_outcomes.push_back(apply_request(op, item));
    endtask

    task automatic idle_burst(input int unsigned cycles);
        if (start) begin
            start <= 1'b0;
        end
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        if (start) begin
            start <= 1'b0;
        end
        while (expected_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic note_mismatch(input string what);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (expected_outcomes.size() == 0) begin
                note_mismatch($sformatf("result with none pending: status %0d occupancy %0d",
                                        o_status, o_occupancy));
            end else begin
                want = expected_outcomes.pop_front();
                if (o_status !== want.status || o_out_priority !== want.removed.prio ||
                    o_out_record !== want.removed.rec || o_out_age !== want.removed.age ||
                    o_occupancy !== want.occupancy) begin
                    note_mismatch($sformatf({"exp st=%0d pri=%h rec=%h age=%h occ=%0d, ",
                                             "got st=%0d pri=%h rec=%h age=%h occ=%0d"},
                        want.status, want.removed.prio, want.removed.rec, want.removed.age,
                        want.occupancy, o_status, o_out_priority, o_out_record, o_out_age,
                        o_occupancy));
                end
            end
        end
    end

    // Stop a hung run: count cycles with neither a request nor a result taken.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic test_empty_remove();
        send_request(spq_pkg::OP_REMOVE, make_entry(8'h00, 16'h0000, 8'h00));
        send_request(spq_pkg::OP_REMOVE, make_entry(8'hFF, 16'hFFFF, 8'hFF));
    endtask

    task automatic test_order_and_ties();
        send_request(spq_pkg::OP_INSERT, make_entry(8'h00, 16'h0000, 8'h00));
        send_request(spq_pkg::OP_INSERT, make_entry(8'hFF, 16'hFFFF, 8'hFF));
        send_request(spq_pkg::OP_INSERT, make_entry(8'h80, 16'h0001, 8'h11));
        send_request(spq_pkg::OP_INSERT, make_entry(8'h80, 16'h0002, 8'h22));
        send_request(spq_pkg::OP_INSERT, make_entry(8'h80, 16'h0003, 8'h33));
        send_request(spq_pkg::OP_INSERT, make_entry(8'h7F, 16'h5555, 8'h55));
        send_request(spq_pkg::OP_INSERT, make_entry(8'h81, 16'hAAAA, 8'hAA));
        send_request(spq_pkg::OP_INSERT, make_entry(8'hFF, 16'h1234, 8'h01));
        send_request(spq_pkg::OP_INSERT, make_entry(8'h00, 16'h4321, 8'hFE));
        wait_drained();
    endtask

    task automatic test_full_queue();
        while (shadow_count < spq_pkg::CAPACITY) begin
            send_request(spq_pkg::OP_INSERT, random_entry(1'b0));
        end
        send_request(spq_pkg::OP_INSERT, make_entry(8'hFF, 16'hFFFF, 8'hFF));
        send_request(spq_pkg::OP_INSERT, make_entry(8'h00, 16'h0000, 8'h00));
        repeat (3) send_request(spq_pkg::OP_REMOVE, random_entry(1'b0));
    endtask

    task automatic test_random_traffic(input int unsigned count, input bit with_gaps);
        int unsigned      n;
        int unsigned      burst_left;
        int unsigned      insert_pct;
        bit               tie_heavy;
        spq_pkg::t_opcode op;
        burst_left = 0;
        insert_pct = 50;
        tie_heavy  = 1'b0;
        for (n = 0; n < count; n++) begin
            // switch between fill, drain and mixed phases so both ends get reached
            if (burst_left == 0) begin
                burst_left = $urandom_range(4, 40);
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 20;
                    default: insert_pct = 55;
                endcase
                tie_heavy = 1'($urandom_range(0, 1));
            end
            burst_left--;
            op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT
                                                       : spq_pkg::OP_REMOVE;
            if (with_gaps && $urandom_range(0, 3) == 0) begin
                idle_burst($urandom_range(1, 9));
            end
            send_request(op, random_entry(tie_heavy));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_remove();
        test_order_and_ties();
        test_full_queue();
        test_random_traffic(300, 1'b1);
        wait_drained();
        test_random_traffic(260, 1'b1);
        test_random_traffic(70, 1'b0);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
